>>> hdl/tax_code_check_digit_validator_macros.svh
// ----------------------------------------------------------------------------
// Tax code check-digit validator assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TAX_CODE_CHECK_DIGIT_VALIDATOR_MACROS_SVH
`define TAX_CODE_CHECK_DIGIT_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCDV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCDV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tcdv_pkg.sv
// ----------------------------------------------------------------------------
// Tax code check-digit validator package
// Types, status codes, character constants and small arithmetic helpers.
// ----------------------------------------------------------------------------
package tcdv_pkg;

    typedef struct packed {
        logic       func;
        logic [7:0] character;
        logic       last;
    } item_t;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_LENGTH = 2'd1;
    localparam logic [1:0] STATUS_BAD    = 2'd2;

    localparam logic MODE_VAT = 1'b0;
    localparam logic MODE_FC  = 1'b1;

    localparam logic [7:0] CH_0 = 8'd48;
    localparam logic [7:0] CH_9 = 8'd57;
    localparam logic [7:0] CH_A = 8'd65;
    localparam logic [7:0] CH_Z = 8'd90;

    localparam logic [4:0] VAT_LEN       = 5'd11;
    localparam logic [4:0] FC_LEN        = 5'd16;
    localparam logic [4:0] VAT_CHECK_POS = 5'd10;
    localparam logic [4:0] FC_CHECK_POS  = 5'd15;
    localparam logic [4:0] POS_MAX       = 5'd31;

    function automatic logic [4:0] odd_value(input logic [4:0] idx);
        logic [4:0] v;
        case (idx)
            5'd0:  v = 5'd1;
            5'd1:  v = 5'd0;
            5'd2:  v = 5'd5;
            5'd3:  v = 5'd7;
            5'd4:  v = 5'd9;
            5'd5:  v = 5'd13;
            5'd6:  v = 5'd15;
            5'd7:  v = 5'd17;
            5'd8:  v = 5'd19;
            5'd9:  v = 5'd21;
            5'd10: v = 5'd2;
            5'd11: v = 5'd4;
            5'd12: v = 5'd18;
            5'd13: v = 5'd20;
            5'd14: v = 5'd11;
            5'd15: v = 5'd3;
            5'd16: v = 5'd6;
            5'd17: v = 5'd8;
            5'd18: v = 5'd12;
            5'd19: v = 5'd14;
            5'd20: v = 5'd16;
            5'd21: v = 5'd10;
            5'd22: v = 5'd22;
            5'd23: v = 5'd25;
            5'd24: v = 5'd24;
            5'd25: v = 5'd23;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

    // Reciprocal multiply; exact for every 9-bit value.
    function automatic logic [3:0] mod10(input logic [8:0] s);
        logic [17:0] prod;
        logic [8:0]  q;
        logic [8:0]  r;
        prod = 18'(s) * 18'd205;
        q    = 9'(prod[17:11]);
        r    = s - 9'(q * 9'd10);
        return r[3:0];
    endfunction

    // Reciprocal multiply that may undershoot by one, then one correction.
    function automatic logic [4:0] mod26(input logic [8:0] s);
        logic [17:0] prod;
        logic [8:0]  q;
        logic [8:0]  r;
        prod = 18'(s) * 18'd315;
        q    = 9'(prod[17:13]);
        r    = s - 9'(q * 9'd26);
        if (r >= 9'd26)
        begin
            r = r - 9'd26;
        end
        return r[4:0];
    endfunction

endpackage

>>> hdl/tcdv_item_if.sv
// ----------------------------------------------------------------------------
// Tax code character channel
// Valid/ready channel that carries one code character per request.
// ----------------------------------------------------------------------------
interface tcdv_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output func, output character, output last, input ready);
    modport sink (input valid, input func, input character, input last, output ready);
endinterface

>>> hdl/tcdv_result_if.sv
// ----------------------------------------------------------------------------
// Tax code result channel
// Valid/ready channel that carries one validation status per request.
// ----------------------------------------------------------------------------
interface tcdv_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;

    modport source (output valid, output status, input ready);
    modport sink (input valid, input status, output ready);
endinterface

>>> hdl/tcdv_in_stage.sv
// ----------------------------------------------------------------------------
// Tax code input stage
// Registers one incoming character and hands it to the checking logic.
// ----------------------------------------------------------------------------
module tcdv_in_stage
    import tcdv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  in_ready,
    input  logic  take,
    output logic  stage_valid,
    output item_t stage_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready    = !valid_reg || take;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> hdl/tcdv_core.sv
// ----------------------------------------------------------------------------
// Tax code checking core
// Per-character classification, checksum update and final status decision.
// ----------------------------------------------------------------------------
module tcdv_core
    import tcdv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       stage_valid,
    input  item_t      stage_item,
    input  logic       out_free,
    output logic       take,
    output logic       res_valid,
    output logic [1:0] res_status
);

    logic [4:0] pos_reg;
    logic [8:0] sum_reg;
    logic       mode_reg;
    logic       bad_reg;
    logic       head_zero_reg;
    logic       tail_zero_reg;
    logic       mismatch_reg;

    logic [4:0] pos_next;
    logic [8:0] sum_next;
    logic       mode_next;
    logic       bad_next;
    logic       head_zero_next;
    logic       tail_zero_next;
    logic       mismatch_next;

    logic       mode;
    logic       is_digit;
    logic       is_upper;
    logic [3:0] digit;
    logic [4:0] letter;
    logic [4:0] dbl;
    logic [3:0] rem10;
    logic [3:0] want;
    logic [4:0] rem26;
    logic       letter_slot;
    logic [4:0] fc_value;
    logic [4:0] count;
    logic [1:0] status;

    assign take       = stage_valid && (!stage_item.last || out_free);
    assign res_valid  = take && stage_item.last;
    assign res_status = status;

    always_comb
    begin
        mode     = (pos_reg == 5'd0) ? stage_item.func : mode_reg;
        is_digit = stage_item.character inside {[CH_0:CH_9]};
        is_upper = stage_item.character inside {[CH_A:CH_Z]};
        digit    = stage_item.character[3:0];
        letter   = 5'(stage_item.character - CH_A);
        dbl      = (digit > 4'd4) ? 5'({digit, 1'b0} - 5'd9) : {digit, 1'b0};
        rem10    = mod10(sum_reg);
        want     = (rem10 == 4'd0) ? 4'd0 : 4'(4'd10 - rem10);
        rem26    = mod26(sum_reg);
        letter_slot = (pos_reg < 5'd6) || (pos_reg == 5'd8) || (pos_reg == 5'd11);
        fc_value = letter_slot ? letter : 5'(digit);
        count    = (pos_reg == POS_MAX) ? POS_MAX : 5'(pos_reg + 5'd1);

        sum_next       = sum_reg;
        bad_next       = bad_reg;
        head_zero_next = head_zero_reg;
        tail_zero_next = tail_zero_reg;
        mismatch_next  = mismatch_reg;

        if (mode == MODE_VAT)
        begin
            if (pos_reg <= VAT_CHECK_POS)
            begin
                if (!is_digit)
                begin
                    bad_next       = 1'b1;
                    head_zero_next = 1'b0;
                    tail_zero_next = 1'b0;
                end
                else
                begin
                    if (pos_reg < 5'd7 && digit != 4'd0)
                    begin
                        head_zero_next = 1'b0;
                    end
                    if (pos_reg >= 5'd7 && pos_reg <= 5'd9 && digit != 4'd0)
                    begin
                        tail_zero_next = 1'b0;
                    end
                    if (pos_reg < VAT_CHECK_POS)
                    begin
                        sum_next = pos_reg[0] ? sum_reg + 9'(dbl) : sum_reg + 9'(digit);
                    end
                    else if (digit != want)
                    begin
                        mismatch_next = 1'b1;
                    end
                end
            end
        end
        else
        begin
            if (pos_reg == FC_CHECK_POS)
            begin
                if (stage_item.character != 8'(CH_A + 8'(rem26)))
                begin
                    mismatch_next = 1'b1;
                end
            end
            else if (pos_reg < FC_CHECK_POS)
            begin
                if ((letter_slot && !is_upper) || (!letter_slot && !is_digit))
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    sum_next = pos_reg[0] ? sum_reg + 9'(fc_value)
                                          : sum_reg + 9'(odd_value(fc_value));
                end
            end
        end

        if (mode == MODE_VAT)
        begin
            if (count != VAT_LEN)
            begin
                status = STATUS_LENGTH;
            end
            else if (bad_next || head_zero_next || tail_zero_next || mismatch_next)
            begin
                status = STATUS_BAD;
            end
            else
            begin
                status = STATUS_OK;
            end
        end
        else
        begin
            if (count != FC_LEN)
            begin
                status = STATUS_LENGTH;
            end
            else if (bad_next || mismatch_next)
            begin
                status = STATUS_BAD;
            end
            else
            begin
                status = STATUS_OK;
            end
        end

        pos_next  = count;
        mode_next = mode;
        if (stage_item.last)
        begin
            pos_next       = 5'd0;
            sum_next       = 9'd0;
            mode_next      = MODE_VAT;
            bad_next       = 1'b0;
            head_zero_next = 1'b1;
            tail_zero_next = 1'b1;
            mismatch_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 5'd0;
            sum_reg       <= 9'd0;
            mode_reg      <= MODE_VAT;
            bad_reg       <= 1'b0;
            head_zero_reg <= 1'b1;
            tail_zero_reg <= 1'b1;
            mismatch_reg  <= 1'b0;
        end
        else if (take)
        begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            mode_reg      <= mode_next;
            bad_reg       <= bad_next;
            head_zero_reg <= head_zero_next;
            tail_zero_reg <= tail_zero_next;
            mismatch_reg  <= mismatch_next;
        end
    end

endmodule

>>> hdl/tcdv_out_stage.sv
// ----------------------------------------------------------------------------
// Tax code result stage
// Holds one finished status until the downstream side takes it.
// ----------------------------------------------------------------------------
module tcdv_out_stage
    import tcdv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_valid,
    input  logic [1:0] res_status,
    output logic       out_free,
    output logic       out_valid,
    output logic [1:0] out_status,
    input  logic       out_ready
);

    logic       valid_reg;
    logic       valid_next;
    logic [1:0] status_reg;

    assign out_free   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_status = status_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            status_reg <= res_status;
        end
    end

endmodule

>>> hdl/tax_code_check_digit_validator.sv
// A status goes from the input register through the core into the result register.
// Throughput: one character and checksum update per cycle, but for the stall below.
// The input register keeps taking characters while a status waits downstream,
// until a final character has to wait behind that status.
// Reset: rst_n (asynchronous, active low) empties both registers and starts a new code.
// ----------------------------------------------------------------------------
// Tax code check-digit validator
// Validates Italian VAT numbers and fiscal codes one character at a time.
// ----------------------------------------------------------------------------
module tax_code_check_digit_validator
    import tcdv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    tcdv_item_if.sink     item,
    tcdv_result_if.source result
);

    item_t      in_item;
    item_t      stage_item;
    logic       stage_valid;
    logic       take;
    logic       out_free;
    logic       res_valid;
    logic [1:0] res_status;

    assign in_item = '{func: item.func, character: item.character, last: item.last};

    tcdv_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (item.valid),
        .in_item     (in_item),
        .in_ready    (item.ready),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    tcdv_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .out_free    (out_free),
        .take        (take),
        .res_valid   (res_valid),
        .res_status  (res_status)
    );

    tcdv_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res_status (res_status),
        .out_free   (out_free),
        .out_valid  (result.valid),
        .out_status (result.status),
        .out_ready  (result.ready)
    );

endmodule

>>> hdl/tcdv_checker.sv
// ----------------------------------------------------------------------------
// Tax code validator port checker
// Watches the top-level ports and checks request accounting and flow.
// ----------------------------------------------------------------------------
`include "tax_code_check_digit_validator_macros.svh"

module tcdv_checker
    import tcdv_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_status
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       last_taken;
    logic       result_taken;

    assign last_taken   = in_valid && in_ready && in_last;
    assign result_taken = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (last_taken && !result_taken)
        begin
            pending_next = 2'(pending_reg + 2'd1);
        end
        else if (!last_taken && result_taken)
        begin
            pending_next = 2'(pending_reg - 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `TCDV_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status), "result dropped or changed while stalled")
    `TCDV_ASSERT_SAME(a_no_extra_result, clk, rst_n, out_valid, pending_reg != 2'd0, "result without a final character")
    `TCDV_ASSERT_SAME(a_pending_bound, clk, rst_n, 1'b1, pending_reg != 2'd3, "more codes in flight than registers")
    `TCDV_ASSERT_SAME(a_ready_when_drained, clk, rst_n, !out_valid, in_ready, "input stalled with an empty result register")

endmodule

bind tax_code_check_digit_validator tcdv_checker u_tcdv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .in_last    (item.last),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_status (result.status)
);
